### rtl/core/swta_pkg.sv
// Shared types and constants for the weighted server task assigner.
package swta_pkg;

  // Default sizes of the server pool and its time and weight words
  localparam int SERVERS_DEF     = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths on the stream ports
  localparam int IDX_FIELD_W   = 4;
  localparam int WGT_FIELD_W   = 16;
  localparam int DUR_FIELD_W   = 16;
  localparam int START_FIELD_W = 32;
  localparam int CFG_W         = 5;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  // Server count after reset
  localparam logic [CFG_W-1:0] CFG_COUNT_RST = 5'd16;

  // Transaction kinds carried on in_tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TASK = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;   // start a new scan
    logic sample;  // a server entry is on the data inputs
    logic first;   // that entry is server 0
  } cmp_ctrl_t;

endpackage

### rtl/core/swta_ram.sv
// Single-port-write, single-port-read table with registered read data.
module swta_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/swta_cmp.sv
// Shared compare unit: tracks the best free and the best busy server over a scan.
module swta_cmp #(
  parameter int IDX_W       = 4,
  parameter int TIME_BITS   = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swta_pkg::cmp_ctrl_t    ctrl,
  input  logic [IDX_W-1:0]       idx,
  input  logic [TIME_BITS-1:0]   end_time,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [TIME_BITS-1:0]   now,
  output logic                   have_free,
  output logic [IDX_W-1:0]       free_idx,
  output logic [IDX_W-1:0]       busy_idx,
  output logic [TIME_BITS-1:0]   earliest
);

  logic                   have_free_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic [WEIGHT_BITS-1:0] free_w_r;
  logic [IDX_W-1:0]       busy_idx_r;
  logic [WEIGHT_BITS-1:0] busy_w_r;
  logic [TIME_BITS-1:0]   earliest_r;
  logic                   is_free;
  logic                   take_free;
  logic                   take_busy;

  // candidate decisions; scan runs in index order so strict compares keep lowest index
  always_comb begin
    is_free   = (end_time <= now);
    take_free = is_free && (!have_free_r || (weight < free_w_r));
    take_busy = ctrl.first || (end_time < earliest_r) ||
                ((end_time == earliest_r) && (weight < busy_w_r));
  end

  // free flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_free_r <= 1'b0;
    end else if (ctrl.clear) begin
      have_free_r <= 1'b0;
    end else if (ctrl.sample && is_free) begin
      have_free_r <= 1'b1;
    end
  end

  // best candidates
  always_ff @(posedge clk) begin
    if (ctrl.sample) begin
      if (take_free) begin
        free_idx_r <= idx;
        free_w_r   <= weight;
      end
      if (take_busy) begin
        busy_idx_r <= idx;
        busy_w_r   <= weight;
        earliest_r <= end_time;
      end
    end
  end

  assign have_free = have_free_r;
  assign free_idx  = free_idx_r;
  assign busy_idx  = busy_idx_r;
  assign earliest  = earliest_r;

endmodule

### rtl/core/weighted_server_task_assigner.sv
// Top level: weighted server task assigner with sequencer, tables and output register.
//
// Usage: in_tuser selects the transaction kind. A load (in_tuser = 0) stores
// the weight for server in_tdata[3:0] and gives no result; an index at or
// above the pool size is dropped. A task (in_tuser = 1) carries its duration
// in in_tdata[35:20] and gives one result on the out_ channel: the chosen
// server in out_tdata[3:0] and its start time in out_tdata[35:4]. A task is
// handled by a single compare unit that visits the active servers one per
// cycle out of the end-time and weight tables; in_tready stays low from the
// acceptance of a task through its scan and update steps, and the result is
// loaded into the output register as the update step completes, so no new
// load or task is taken until that task's result has been registered.
// in_tready is high only while the sequencer is idle; a result waiting for
// out_tready does not block the next load or the next task's scan, but a
// finished task holds in its update step until the output register frees up.
// cfg_wr_en writes the server count at any clock edge; it is meant to
// change only while the block is idle.
// Reset (rst_n low, synchronous) makes all servers free, time and task count
// zero, server count 16; weights are undefined until loaded.
module weighted_server_task_assigner #(
  parameter int SERVERS     = swta_pkg::SERVERS_DEF,
  parameter int TIME_BITS   = swta_pkg::TIME_BITS_DEF,
  parameter int WEIGHT_BITS = swta_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration: server count
  input  logic                                cfg_wr_en,
  input  logic [swta_pkg::CFG_W-1:0]          cfg_wr_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [swta_pkg::IN_TDATA_W-1:0]     in_tdata,  // server_index, weight, duration, pad
  input  logic                                in_tuser,  // mode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [swta_pkg::OUT_TDATA_W-1:0]    out_tdata  // assigned_server, start_time, pad
);

  localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CNT_W = $clog2(SERVERS + 1);
  localparam int CMP_W = 10;

  swta_pkg::state_t    state_r, state_nxt;
  swta_pkg::cmp_ctrl_t cmp_ctrl;

  logic [swta_pkg::CFG_W-1:0] cfg_count_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]           rd_idx_r;
  logic                       rd_evld_r;
  logic [TIME_BITS-1:0]       t_r, t_nxt;
  logic [TIME_BITS-1:0]       dur_r, dur_nxt;
  logic [TIME_BITS-1:0]       cur_time_r, cur_time_nxt;
  logic [TIME_BITS-1:0]       task_cnt_r, task_cnt_nxt;
  logic [SERVERS-1:0]         evld_r;
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [IDX_W-1:0]           out_idx_r, out_idx_nxt;
  logic [TIME_BITS-1:0]       out_time_r, out_time_nxt;

  logic                       in_fire;
  logic                       finish;
  logic [swta_pkg::IDX_FIELD_W-1:0] in_idx;
  logic [IDX_W-1:0]           raddr;
  logic                       wgt_we;
  logic                       end_we;
  logic [WEIGHT_BITS-1:0]     wgt_rdata;
  logic [TIME_BITS-1:0]       end_rdata;
  logic [TIME_BITS-1:0]       end_val;
  logic                       have_free;
  logic [IDX_W-1:0]           free_idx;
  logic [IDX_W-1:0]           busy_idx;
  logic [TIME_BITS-1:0]       earliest;
  logic [TIME_BITS-1:0]       t_fin;
  logic [IDX_W-1:0]           idx_fin;
  logic [TIME_BITS:0]         end_sum;
  logic [TIME_BITS-1:0]       end_new;

  assign in_idx    = in_tdata[3:0];
  assign in_tready = (state_r == swta_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign raddr     = cnt_r[IDX_W-1:0];

  // final pick and saturating end time
  always_comb begin
    t_fin   = have_free ? t_r : earliest;
    idx_fin = have_free ? free_idx : busy_idx;
    end_sum = {1'b0, t_fin} + {1'b0, dur_r};
    end_new = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];
  end

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    n_nxt           = n_r;
    rd_vld_nxt      = 1'b0;
    t_nxt           = t_r;
    dur_nxt         = dur_r;
    cur_time_nxt    = cur_time_r;
    task_cnt_nxt    = task_cnt_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_idx_nxt     = out_idx_r;
    out_time_nxt    = out_time_r;
    wgt_we          = 1'b0;
    end_we          = 1'b0;
    finish          = 1'b0;
    cmp_ctrl.clear  = 1'b0;
    cmp_ctrl.sample = rd_vld_r;
    cmp_ctrl.first  = (rd_idx_r == '0);
    unique case (state_r)
      swta_pkg::ST_IDLE: begin
        if (in_fire && (in_tuser == swta_pkg::MODE_LOAD)) begin
          wgt_we = (CMP_W'(in_idx) < CMP_W'(SERVERS));
        end else if (in_fire) begin
          cmp_ctrl.clear = 1'b1;
          cnt_nxt        = '0;
          dur_nxt        = TIME_BITS'(in_tdata[35:20]);
          t_nxt          = (cur_time_r > task_cnt_r) ? cur_time_r : task_cnt_r;
          // server count 0 acts as 1, above the pool acts as the pool size
          if (cfg_count_r == '0) begin
            n_nxt = CNT_W'(1);
          end else if (CMP_W'(cfg_count_r) > CMP_W'(SERVERS)) begin
            n_nxt = CNT_W'(SERVERS);
          end else begin
            n_nxt = CNT_W'(cfg_count_r);
          end
          state_nxt = swta_pkg::ST_SCAN;
        end
      end
      swta_pkg::ST_SCAN: begin
        // one table read per cycle; the last sample lands as the state moves on
        if (cnt_r < n_r) begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = swta_pkg::ST_UPDATE;
        end
      end
      swta_pkg::ST_UPDATE: begin
        if (!out_tvalid_r || out_tready) begin
          finish         = 1'b1;
          end_we         = 1'b1;
          cur_time_nxt   = t_fin;
          task_cnt_nxt   = (task_cnt_r == '1) ? task_cnt_r : task_cnt_r + TIME_BITS'(1);
          out_tvalid_nxt = 1'b1;
          out_idx_nxt    = idx_fin;
          out_time_nxt   = t_fin;
          state_nxt      = swta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swta_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swta_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r  <= swta_pkg::CFG_COUNT_RST;
      rd_vld_r     <= 1'b0;
      cur_time_r   <= '0;
      task_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
      evld_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
      rd_vld_r     <= rd_vld_nxt;
      cur_time_r   <= cur_time_nxt;
      task_cnt_r   <= task_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (end_we) begin
        evld_r[idx_fin] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    t_r        <= t_nxt;
    dur_r      <= dur_nxt;
    out_idx_r  <= out_idx_nxt;
    out_time_r <= out_time_nxt;
    rd_idx_r   <= raddr;
    rd_evld_r  <= evld_r[raddr];
  end

  // weight table
  swta_ram #(
    .W     (WEIGHT_BITS),
    .DEPTH (SERVERS),
    .AW    (IDX_W)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (IDX_W'(in_idx)),
    .wdata (WEIGHT_BITS'(in_tdata[19:4])),
    .raddr (raddr),
    .rdata (wgt_rdata)
  );

  // end-time table; never-written entries read as zero through the valid bits
  swta_ram #(
    .W     (TIME_BITS),
    .DEPTH (SERVERS),
    .AW    (IDX_W)
  ) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (idx_fin),
    .wdata (end_new),
    .raddr (raddr),
    .rdata (end_rdata)
  );

  assign end_val = rd_evld_r ? end_rdata : '0;

  // shared compare unit
  swta_cmp #(
    .IDX_W       (IDX_W),
    .TIME_BITS   (TIME_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (cmp_ctrl),
    .idx       (rd_idx_r),
    .end_time  (end_val),
    .weight    (wgt_rdata),
    .now       (t_r),
    .have_free (have_free),
    .free_idx  (free_idx),
    .busy_idx  (busy_idx),
    .earliest  (earliest)
  );

  // result port
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, swta_pkg::START_FIELD_W'(out_time_r),
                       swta_pkg::IDX_FIELD_W'(out_idx_r)};

  // a new result appears only when a task finishes its update step
  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(state_r == swta_pkg::ST_UPDATE))
    else $error("result raised outside the update step");

  // an accepted task always starts a scan
  a_task_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == swta_pkg::MODE_TASK))
      |=> (state_r == swta_pkg::ST_SCAN))
    else $error("task accepted without a scan");

  // table samples only arrive while scanning
  a_sample_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == swta_pkg::ST_SCAN))
    else $error("table sample outside the scan");

  // the chosen server is marked as having a stored end time
  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> evld_r[$past(idx_fin)])
    else $error("end time written without its valid bit");

endmodule
